@@ hw/rtl/trial_division_prime_counter_assert.svh @@
// assertion macros for the trial division prime counter checker
`ifndef TRIAL_DIVISION_PRIME_COUNTER_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_COUNTER_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define TDPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdpc assertion failed");

// next-cycle implication, clocked on clk, quiet during reset
`define TDPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdpc assertion failed");

`endif

@@ hw/rtl/tdpc_pkg.sv @@
// shared types and constants for the trial division prime counter
package tdpc_pkg;

    localparam int unsigned SMALLEST_PRIME    = 2;
    localparam int unsigned FIRST_ODD_DIVISOR = 3;
    localparam int unsigned DIVISOR_STEP      = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_DONE
    } tdpc_state_t;

    typedef struct packed {
        logic start;
    } tdpc_mod_ctrl_t;

    typedef struct packed {
        logic done;
        logic zero;
    } tdpc_mod_stat_t;

    typedef struct packed {
        logic valid;
        logic prime;
        logic last;
    } tdpc_res_t;

endpackage

@@ hw/rtl/tdpc_if.sv @@
// request and result channel interfaces
interface tdpc_item_if #(parameter int VALUE_BITS = 31);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink (input valid, input value, input last_item, output ready);
endinterface

interface tdpc_result_if #(parameter int COUNT_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic                  is_prime;
    logic [COUNT_BITS-1:0] primes_so_far;
    logic                  end_of_array;

    modport source (output valid, output is_prime, output primes_so_far,
                    output end_of_array, input ready);
    modport sink (input valid, input is_prime, input primes_so_far,
                  input end_of_array, output ready);
endinterface

@@ hw/rtl/tdpc_serial_mod.sv @@
// bit-serial restoring remainder unit, one dividend bit per cycle
module tdpc_serial_mod
    import tdpc_pkg::*;
#(
    parameter int VALUE_BITS = 31,
    parameter int DIV_BITS   = 17
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tdpc_mod_ctrl_t        ctrl,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [DIV_BITS-1:0]   divisor,
    output tdpc_mod_stat_t        stat
);

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] shift_reg;
    logic [DIV_BITS-1:0]   rem_reg;
    logic [DIV_BITS-1:0]   rem_next;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic                  zero_reg;
    logic [DIV_BITS:0]     trial;
    logic [DIV_BITS:0]     diff;

    always_comb
    begin
        trial = {rem_reg, shift_reg[VALUE_BITS-1]};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor})
        begin
            rem_next = diff[DIV_BITS-1:0];
        end
        else
        begin
            rem_next = trial[DIV_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(VALUE_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[VALUE_BITS-2:0], 1'b0};
            rem_reg   <= rem_next;
            zero_reg  <= (rem_next == '0);
        end
    end

    assign stat.done = done_reg;
    assign stat.zero = zero_reg;

endmodule

@@ hw/rtl/tdpc_seq.sv @@
// divisor sequencer: steps odd divisors while their square stays within the value
module tdpc_seq
    import tdpc_pkg::*;
#(
    parameter int VALUE_BITS = 31
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic                  in_last,
    output logic                  in_ready,
    input  logic                  take,
    output tdpc_res_t             res
);

    localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_BITS  = VALUE_BITS + 1;

    tdpc_state_t           state_reg;
    tdpc_state_t           state_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  last_reg;
    logic                  prime_reg;
    logic [DIV_BITS-1:0]   div_reg;
    logic [SQ_BITS-1:0]    sq_reg;
    logic                  accept;
    logic                  sq_over;
    tdpc_mod_ctrl_t        mod_ctrl;
    tdpc_mod_stat_t        mod_stat;

    assign accept  = in_valid && in_ready;
    assign sq_over = sq_reg > {1'b0, value_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_value < VALUE_BITS'(SMALLEST_PRIME) || !in_value[0])
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                state_next = sq_over ? ST_DONE : ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (mod_stat.done)
                begin
                    state_next = mod_stat.zero ? ST_DONE : ST_CHECK;
                end
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        mod_ctrl.start = 1'b0;
        res.valid      = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_ready       = 1'b1;
            ST_CHECK:  mod_ctrl.start = !sq_over;
            ST_DIVIDE: ;
            ST_DONE:   res.valid      = 1'b1;
            default:   ;
        endcase
        res.prime = prime_reg;
        res.last  = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= in_value;
            last_reg  <= in_last;
            prime_reg <= (in_value == VALUE_BITS'(SMALLEST_PRIME));
            div_reg   <= DIV_BITS'(FIRST_ODD_DIVISOR);
            sq_reg    <= SQ_BITS'(FIRST_ODD_DIVISOR * FIRST_ODD_DIVISOR);
        end
        else if (state_reg == ST_CHECK && sq_over)
        begin
            prime_reg <= 1'b1;
        end
        else if (state_reg == ST_DIVIDE && mod_stat.done && !mod_stat.zero)
        begin
            // (d+2)^2 = d^2 + 4d + 4
            div_reg <= div_reg + DIV_BITS'(DIVISOR_STEP);
            sq_reg  <= sq_reg + SQ_BITS'({div_reg, 2'b00}) + SQ_BITS'(4);
        end
    end

    tdpc_serial_mod #(
        .VALUE_BITS (VALUE_BITS),
        .DIV_BITS   (DIV_BITS)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mod_ctrl),
        .dividend (value_reg),
        .divisor  (div_reg),
        .stat     (mod_stat)
    );

endmodule

@@ hw/rtl/trial_division_prime_counter.sv @@
// top level: trial division prime test with per-array saturating prime tally
//
//  channel  dir  fields
//  item     in   value[VALUE_BITS], last_item
//  result   out  is_prime, primes_so_far[COUNT_BITS], end_of_array
//
//  one request at a time; values below 2 and even values go from idle straight to done
//  odd values run the bit-serial remainder unit once per odd divisor d (from 3, d*d <= value),
//  stopping at the first divisor that leaves a zero remainder
//  a finished result sits in the output register while the next request is taken
//  async active-low reset clears the tally, the sequencer and the output valid
module trial_division_prime_counter
    import tdpc_pkg::*;
#(
    parameter int VALUE_BITS = 31,
    parameter int COUNT_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    tdpc_item_if.sink     item,
    tdpc_result_if.source result
);

    logic [COUNT_BITS-1:0] tally_reg;
    logic [COUNT_BITS-1:0] count;
    logic                  out_valid_reg;
    logic                  prime_out_reg;
    logic [COUNT_BITS-1:0] count_out_reg;
    logic                  end_out_reg;
    logic                  take;
    tdpc_res_t             res;

    tdpc_seq #(
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_value (item.value),
        .in_last  (item.last_item),
        .in_ready (item.ready),
        .take     (take),
        .res      (res)
    );

    assign take = res.valid && (!out_valid_reg || result.ready);

    always_comb
    begin
        count = tally_reg;
        if (res.prime && tally_reg != '1)
        begin
            count = tally_reg + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
                tally_reg     <= res.last ? '0 : count;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prime_out_reg <= res.prime;
            count_out_reg <= count;
            end_out_reg   <= res.last;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.is_prime      = prime_out_reg;
    assign result.primes_so_far = count_out_reg;
    assign result.end_of_array  = end_out_reg;

endmodule

@@ hw/rtl/tdpc_checker.sv @@
// port-level checker for the trial division prime counter, with its bind
`include "trial_division_prime_counter_assert.svh"

module tdpc_checker
#(
    parameter int COUNT_BITS = 16
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_valid,
    input logic                  item_ready,
    input logic                  result_valid,
    input logic                  result_ready,
    input logic                  is_prime,
    input logic [COUNT_BITS-1:0] primes_so_far,
    input logic                  end_of_array
);

    `TDPC_ASSERT_NEXT(a_result_holds, result_valid && !result_ready,
        result_valid && $stable(primes_so_far) && $stable(is_prime) && $stable(end_of_array))
    `TDPC_ASSERT_NOW(a_prime_counted, result_valid && is_prime, primes_so_far != '0)
    `TDPC_ASSERT_NEXT(a_one_at_a_time, item_valid && item_ready, !item_ready)

endmodule

bind trial_division_prime_counter tdpc_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_tdpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item.valid),
    .item_ready    (item.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .is_prime      (result.is_prime),
    .primes_so_far (result.primes_so_far),
    .end_of_array  (result.end_of_array)
);
